// ----- hdl/mml_pkg.sv -----
// Package for the maximal-munch lexer: sizing constants, token kind codes,
// character codes, item and token structs, and the classification functions.
// No dependencies; every other file in hdl/ imports it.
package mml_pkg;

  // Sizing
  localparam int MAX_TOKEN_LENGTH = 31;
  localparam int POSITION_BITS    = 16;
  localparam int POS_W            = 16;
  localparam int POS_MAX_INT      = (POSITION_BITS < 16) ? ((1 << POSITION_BITS) - 1) : 65535;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(POS_MAX_INT);
  localparam int TOK_LEN_W        = 5;
  localparam int LEN_CAP          = (MAX_TOKEN_LENGTH < 31) ? MAX_TOKEN_LENGTH : 31;
  localparam int RUN_W            = $clog2(MAX_TOKEN_LENGTH + 2);
  localparam int KW_PREFIX_CHARS  = 6;
  localparam int PREFIX_W         = 8 * KW_PREFIX_CHARS;
  localparam int KIND_W           = 6;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input item kinds
  localparam logic IN_CHAR = 1'b0;
  localparam logic IN_END  = 1'b1;

  // Token kinds
  localparam logic [KIND_W-1:0] TK_END      = 6'd0;
  localparam logic [KIND_W-1:0] TK_IDENT    = 6'd1;
  localparam logic [KIND_W-1:0] TK_NUMBER   = 6'd2;
  localparam logic [KIND_W-1:0] TK_STRUCT   = 6'd3;
  localparam logic [KIND_W-1:0] TK_WHILE    = 6'd4;
  localparam logic [KIND_W-1:0] TK_FOR      = 6'd5;
  localparam logic [KIND_W-1:0] TK_RET      = 6'd6;
  localparam logic [KIND_W-1:0] TK_FN       = 6'd7;
  localparam logic [KIND_W-1:0] TK_IF       = 6'd8;
  localparam logic [KIND_W-1:0] TK_LE       = 6'd9;
  localparam logic [KIND_W-1:0] TK_GE       = 6'd10;
  localparam logic [KIND_W-1:0] TK_EQEQ     = 6'd11;
  localparam logic [KIND_W-1:0] TK_NE       = 6'd12;
  localparam logic [KIND_W-1:0] TK_ANDAND   = 6'd13;
  localparam logic [KIND_W-1:0] TK_OROR     = 6'd14;
  localparam logic [KIND_W-1:0] TK_SYM_BASE = 6'd15;
  localparam logic [KIND_W-1:0] TK_ERROR    = 6'd34;
  localparam logic [KIND_W-1:0] TK_NONE     = 6'd0;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_BAR   = 8'h7c;

  localparam int NUM_SYMS = 19;
  localparam logic [7:0] SYM_CHARS [NUM_SYMS] = '{
    8'h28, 8'h29, 8'h7b, 8'h7d, 8'h3b, 8'h3c, 8'h3e, 8'h3d, 8'h2b, 8'h2d,
    8'h2a, 8'h2f, 8'h25, 8'h5e, 8'h26, 8'h7c, 8'h3a, 8'h21, 8'h2c
  };

  // Keywords packed as they shift into the prefix register
  localparam logic [PREFIX_W-1:0] KW_STRUCT = PREFIX_W'(48'h737472756374);
  localparam logic [PREFIX_W-1:0] KW_WHILE  = PREFIX_W'(48'h7768696c65);
  localparam logic [PREFIX_W-1:0] KW_FOR    = PREFIX_W'(48'h666f72);
  localparam logic [PREFIX_W-1:0] KW_RET    = PREFIX_W'(48'h726574);
  localparam logic [PREFIX_W-1:0] KW_FN     = PREFIX_W'(48'h666e);
  localparam logic [PREFIX_W-1:0] KW_IF     = PREFIX_W'(48'h6966);

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_OPER
  } mode_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]    token_kind;
    logic [POS_W-1:0]     start_line;
    logic [POS_W-1:0]     start_column;
    logic [TOK_LEN_W-1:0] token_length;
    logic                 too_long;
    logic                 last_of_item;
  } token_t;

  // All tokens caused by one input item
  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_op_start(input logic [7:0] c);
    return c inside {CH_LT, CH_GT, CH_EQ, CH_BANG, CH_AMP, CH_BAR};
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_CR, CH_NUL};
  endfunction

  function automatic logic [KIND_W-1:0] symbol_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    k = TK_NONE;
    for (int i = 0; i < NUM_SYMS; i++) begin
      if (SYM_CHARS[i] == c) k = TK_SYM_BASE + KIND_W'(i);
    end
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] two_char_kind(input logic [7:0] a,
                                                      input logic [7:0] b);
    logic [KIND_W-1:0] k;
    k = TK_NONE;
    if (b == CH_EQ) begin
      case (a)
        CH_LT:   k = TK_LE;
        CH_GT:   k = TK_GE;
        CH_EQ:   k = TK_EQEQ;
        CH_BANG: k = TK_NE;
        default: k = TK_NONE;
      endcase
    end
    if (a == CH_AMP && b == CH_AMP) k = TK_ANDAND;
    if (a == CH_BAR && b == CH_BAR) k = TK_OROR;
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] keyword_kind(input logic [PREFIX_W-1:0] p,
                                                     input logic [RUN_W-1:0] n);
    logic [KIND_W-1:0] k;
    k = TK_IDENT;
    if (n == RUN_W'(6) && p == KW_STRUCT) k = TK_STRUCT;
    if (n == RUN_W'(5) && p == KW_WHILE)  k = TK_WHILE;
    if (n == RUN_W'(3) && p == KW_FOR)    k = TK_FOR;
    if (n == RUN_W'(3) && p == KW_RET)    k = TK_RET;
    if (n == RUN_W'(2) && p == KW_FN)     k = TK_FN;
    if (n == RUN_W'(2) && p == KW_IF)     k = TK_IF;
    return k;
  endfunction

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    return (v >= POS_MAX) ? POS_MAX : v + POS_W'(1);
  endfunction

endpackage

// ----- hdl/maximal_munch_lexer.sv -----
// Top level of the maximal-munch lexer: front, entry queue and back.
// Depends on mml_pkg, mml_front, mml_queue and mml_back.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   in_data_i  (in_item_t: kind, ch)
//   out      source     out_valid_o / out_stall_i out_data_o (token_t)
//
// One character is taken per cycle while in_stall_o is low; the front
// decides each item in the cycle it is accepted. Tokens leave one per
// unstalled cycle from the output register; a pair of tokens leaves in turn.
// in_stall_o rises only while the four-entry queue is full.
// Reset clears line, column and pending-token state; an END item does too.
module maximal_munch_lexer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mml_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mml_pkg::token_t   out_data_o
);
  import mml_pkg::*;

  logic      accept;
  logic      push;
  logic      pop;
  entry_t    entry;
  entry_t    head;
  q_status_t q_status;

  // Stall the source only when there is no room for a new entry
  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !in_stall_o;

  mml_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .push_o   (push),
    .entry_o  (entry)
  );

  mml_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  mml_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Never write into a full queue
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full) else $error("push into full queue");

  // Never pop an empty queue
  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty) else $error("pop from empty queue");

  // End of input always yields at least the END token
  a_end_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.kind == IN_END) |-> push) else $error("end item lost");

  // END is always the final token of its item
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.token_kind == TK_END) |-> out_data_o.last_of_item)
    else $error("END token without last flag");

endmodule

// ----- hdl/mml_front.sv -----
// Lexer front: accepts characters, keeps the pending-token state and builds
// the zero, one or two tokens each item causes as one queue entry.
// Depends on mml_pkg.
module mml_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  mml_pkg::in_item_t item_i,
  output logic            push_o,
  output mml_pkg::entry_t entry_o
);
  import mml_pkg::*;

  mode_e                mode_q, mode_d;
  logic [7:0]           op_q, op_d;
  logic [PREFIX_W-1:0]  prefix_q, prefix_d;
  logic [RUN_W-1:0]     run_q, run_d;
  logic [POS_W-1:0]     tsl_q, tsl_d;
  logic [POS_W-1:0]     tsc_q, tsc_d;
  logic [POS_W-1:0]     line_q, line_d;
  logic [POS_W-1:0]     col_q, col_d;

  logic [7:0]            c;
  logic                  is_end;
  logic [KIND_W-1:0]     two_k;
  logic                  cont_op;
  logic                  cont_run;
  logic [RUN_W+TOK_LEN_W-1:0] run_ext;
  logic [TOK_LEN_W-1:0]  run_len;
  logic                  run_long;

  token_t first_tok, second_tok;
  logic   first_v, second_v;

  assign c        = item_i.ch;
  assign is_end   = (item_i.kind == IN_END);
  assign two_k    = two_char_kind(op_q, c);
  assign cont_op  = !is_end && (mode_q == MODE_OPER) && (two_k != TK_NONE);
  assign cont_run = !is_end &&
                    (((mode_q == MODE_IDENT) && (is_letter(c) || is_digit(c) || c == CH_UNDER)) ||
                     ((mode_q == MODE_NUMBER) && is_digit(c)));
  assign run_ext  = (RUN_W + TOK_LEN_W)'(run_q);
  assign run_long = (run_q > RUN_W'(MAX_TOKEN_LENGTH));
  assign run_len  = (run_q > RUN_W'(LEN_CAP)) ? TOK_LEN_W'(LEN_CAP) : run_ext[TOK_LEN_W-1:0];

  // Next state
  always_comb begin
    mode_d   = mode_q;
    op_d     = op_q;
    prefix_d = prefix_q;
    run_d    = run_q;
    tsl_d    = tsl_q;
    tsc_d    = tsc_q;
    line_d   = line_q;
    col_d    = col_q;
    if (accept_i) begin
      if (is_end) begin
        mode_d   = MODE_NONE;
        op_d     = '0;
        prefix_d = '0;
        run_d    = '0;
        tsl_d    = '0;
        tsc_d    = '0;
        line_d   = '0;
        col_d    = '0;
      end else if (cont_op) begin
        mode_d = MODE_NONE;
        op_d   = '0;
        col_d  = sat_inc(col_q);
      end else if (cont_run) begin
        if (run_q < RUN_W'(KW_PREFIX_CHARS)) prefix_d = {prefix_q[PREFIX_W-9:0], c};
        if (run_q <= RUN_W'(MAX_TOKEN_LENGTH)) run_d = run_q + RUN_W'(1);
        col_d = sat_inc(col_q);
      end else begin
        mode_d   = MODE_NONE;
        op_d     = '0;
        prefix_d = '0;
        run_d    = '0;
        if (c == CH_NL) begin
          line_d = sat_inc(line_q);
          col_d  = '0;
        end else begin
          if (is_letter(c) || is_digit(c)) begin
            mode_d   = is_letter(c) ? MODE_IDENT : MODE_NUMBER;
            tsl_d    = line_q;
            tsc_d    = col_q;
            prefix_d = {{(PREFIX_W-8){1'b0}}, c};
            run_d    = RUN_W'(1);
          end else if (is_op_start(c)) begin
            mode_d = MODE_OPER;
            tsl_d  = line_q;
            tsc_d  = col_q;
            op_d   = c;
          end
          col_d = sat_inc(col_q);
        end
      end
    end
  end

  // Tokens caused by this item
  always_comb begin
    first_tok  = '0;
    second_tok = '0;
    first_v    = 1'b0;
    second_v   = 1'b0;

    first_tok.start_line   = tsl_q;
    first_tok.start_column = tsc_q;
    if (cont_op) begin
      first_v                = 1'b1;
      first_tok.token_kind   = two_k;
      first_tok.token_length = TOK_LEN_W'(2);
    end else if (!cont_run) begin
      case (mode_q)
        MODE_IDENT: begin
          first_v                = 1'b1;
          first_tok.token_kind   = run_long ? TK_IDENT : keyword_kind(prefix_q, run_q);
          first_tok.token_length = run_len;
          first_tok.too_long     = run_long;
        end
        MODE_NUMBER: begin
          first_v                = 1'b1;
          first_tok.token_kind   = TK_NUMBER;
          first_tok.token_length = run_len;
          first_tok.too_long     = run_long;
        end
        MODE_OPER: begin
          first_v                = 1'b1;
          first_tok.token_kind   = symbol_kind(op_q);
          first_tok.token_length = TOK_LEN_W'(1);
        end
        default: first_v = 1'b0;
      endcase
    end

    second_tok.start_line   = line_q;
    second_tok.start_column = col_q;
    if (is_end) begin
      second_v              = 1'b1;
      second_tok.token_kind = TK_END;
    end else if (!cont_op && !cont_run && c != CH_NL && !is_separator(c) &&
                 !is_letter(c) && !is_digit(c) && !is_op_start(c)) begin
      second_v                = 1'b1;
      second_tok.token_length = TOK_LEN_W'(1);
      second_tok.token_kind   = (symbol_kind(c) != TK_NONE) ? symbol_kind(c) : TK_ERROR;
    end
  end

  // Pack into one entry; the last token of the item carries the flag
  always_comb begin
    entry_o.two    = first_v && second_v;
    entry_o.first  = first_v ? first_tok : second_tok;
    entry_o.second = second_tok;
    entry_o.first.last_of_item  = !(first_v && second_v);
    entry_o.second.last_of_item = 1'b1;
  end

  assign push_o = accept_i && (first_v || second_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NONE;
      op_q     <= '0;
      prefix_q <= '0;
      run_q    <= '0;
      tsl_q    <= '0;
      tsc_q    <= '0;
      line_q   <= '0;
      col_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      op_q     <= op_d;
      prefix_q <= prefix_d;
      run_q    <= run_d;
      tsl_q    <= tsl_d;
      tsc_q    <= tsc_d;
      line_q   <= line_d;
      col_q    <= col_d;
    end
  end

endmodule

// ----- hdl/mml_queue.sv -----
// Short register queue of token entries between lexer front and back.
// Depends on mml_pkg.
module mml_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mml_pkg::entry_t    entry_i,
  input  logic               pop_i,
  output mml_pkg::entry_t    head_o,
  output mml_pkg::q_status_t status_o
);
  import mml_pkg::*;

  entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign head_o         = mem_q[rd_q];
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + QCNT_W'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + QPTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

endmodule

// ----- hdl/mml_back.sv -----
// Lexer back: pops entries and presents their tokens one per unstalled
// cycle from an output register, holding a pair's second token. Depends on mml_pkg.
module mml_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mml_pkg::entry_t    head_i,
  input  mml_pkg::q_status_t status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mml_pkg::token_t    out_data_o
);
  import mml_pkg::*;

  logic   out_valid_q, out_valid_d;
  token_t out_q, out_d;
  logic   held_v_q, held_v_d;
  token_t held_q, held_d;
  logic   free;

  assign free        = !out_valid_q || !out_stall_i;
  assign pop_o       = free && !held_v_q && !status_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    held_v_d    = held_v_q;
    held_d      = held_q;
    if (free) begin
      if (held_v_q) begin
        out_valid_d = 1'b1;
        out_d       = held_q;
        held_v_d    = 1'b0;
      end else if (!status_i.empty) begin
        out_valid_d = 1'b1;
        out_d       = head_i.first;
        held_v_d    = head_i.two;
        held_d      = head_i.second;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_v_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      held_v_q    <= held_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    held_q <= held_d;
  end

endmodule
